### hdl/vna_pkg.sv
// Package for the vertex normal accumulator: actions, sequencer states, sizes.
// No dependencies; used by vertex_normal_accumulator.
package vna_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERT_CAP = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_TRI    = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_GOT_C,
    S_CROSS,
    S_ABS,
    S_SHIFT,
    S_SQ,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_ACC_RD,
    S_ACC_WR,
    S_FIN_RD,
    S_FIN_GOT,
    S_EMIT
  } state_t;

  localparam logic signed [24:0] SUM_MAX = 25'sd8388607;
  localparam logic signed [24:0] SUM_MIN = -25'sd8388608;

endpackage

### hdl/vertex_normal_accumulator.sv
// Smooth vertex normals of a triangle mesh.
// Channels: one input (action, position, corners), one output (vertex normals).
// Items are accepted one at a time: in_stall stays high while an item is in work.
// A load does not stall the input. A live triangle holds the input through three
// vertex reads, six products and three squares on one shared 32x32 multiplier
// with up to five prescale shifts between them, a square root of 32 one-bit steps,
// three restoring divides of 15 steps each, then three read-modify-write passes
// on the accumulator memory. A finish sends one normal per loaded vertex, each
// through the same normalize sequence;
// the finish item holds the input until the last normal is transferred.
// The output holds its payload and out_valid while out_stall is high; the
// sequencer waits on it. Results that no triangle touched come out as zero.
// Reset (rst, synchronous) empties the vertex count and marks all accumulators
// as zero through per-entry valid bits; no clearing pass is needed, so the
// block takes items in the first cycle after reset.
module vertex_normal_accumulator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic signed [15:0]       pos_x,
  input  logic signed [15:0]       pos_y,
  input  logic signed [15:0]       pos_z,
  input  logic [vna_pkg::IDX_W-1:0] corner_a,
  input  logic [vna_pkg::IDX_W-1:0] corner_b,
  input  logic [vna_pkg::IDX_W-1:0] corner_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [vna_pkg::IDX_W-1:0] vertex_number,
  output logic signed [15:0]       normal_x,
  output logic signed [15:0]       normal_y,
  output logic signed [15:0]       normal_z,
  output logic                     last
);
  import vna_pkg::*;

  state_t state, state_next;

  logic [47:0] vmem [VERT_CAP];
  logic [71:0] smem [VERT_CAP];
  logic [VERT_CAP-1:0] svalid;
  logic [47:0] vdata, va, vb;
  logic [71:0] sdata;
  logic [IDX_W-1:0] vrd_addr, srd_addr;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] corner [3];
  logic [1:0] ci, di;
  logic [IDX_W-1:0] fidx;
  logic emit_mode;

  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [2:0] cnt;
  logic signed [34:0] first;
  logic signed [34:0] cv [3];
  logic [34:0] mag [3];
  logic neg [3];
  logic [61:0] sumsq;
  logic [62:0] sres, sbit;
  logic [63:0] sq_try;
  logic [45:0] rem, den;
  logic [3:0] k;
  logic [14:0] q, qf;
  logic ge;
  logic signed [15:0] nrm [3];
  logic [1:0] sq_sel;
  logic tri_ok, is_last, over;
  logic [71:0] cur;
  logic signed [24:0] s25 [3];
  logic signed [23:0] sat [3];

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign vertex_number = fidx;
  assign normal_x = nrm[0];
  assign normal_y = nrm[1];
  assign normal_z = nrm[2];
  assign is_last = (({1'b0, fidx} + 7'd1) == count);
  assign last = is_last;

  assign tri_ok = ({1'b0, corner_a} < count) && ({1'b0, corner_b} < count) &&
                  ({1'b0, corner_c} < count);
  assign over = (|mag[0][34:30]) | (|mag[1][34:30]) | (|mag[2][34:30]);

  assign sq_try = {1'b0, sres} + {1'b0, sbit};
  assign den = 46'(sres[31:0]) << k;
  assign ge = (rem >= den);
  assign qf = {q[13:0], ge};
  assign cur = svalid[srd_addr] ? sdata : 72'd0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s25[i] = 25'(signed'(cur[71-24*i -: 24])) + 25'(nrm[i]);
      if (s25[i] > SUM_MAX) sat[i] = 24'(SUM_MAX);
      else if (s25[i] < SUM_MIN) sat[i] = 24'(SUM_MIN);
      else sat[i] = s25[i][23:0];
    end
  end

  always_comb begin
    vrd_addr = corner[0];
    unique case (state)
      S_RD_B:  vrd_addr = corner[1];
      S_RD_C:  vrd_addr = corner[2];
      default: vrd_addr = corner[0];
    endcase
    srd_addr = (state == S_FIN_RD || state == S_FIN_GOT) ? fidx : corner[ci];
  end

  // shared multiplier operand select
  always_comb begin
    sq_sel = (cnt[1:0] == 2'd3) ? 2'd0 : cnt[1:0];
    mul_a = 32'(e1[1]);
    mul_b = 32'(e2[2]);
    if (state == S_SQ) begin
      mul_a = {2'b0, mag[sq_sel][29:0]};
      mul_b = {2'b0, mag[sq_sel][29:0]};
    end else begin
      case (cnt)
        3'd1: begin mul_a = 32'(e1[2]); mul_b = 32'(e2[1]); end
        3'd2: begin mul_a = 32'(e1[2]); mul_b = 32'(e2[0]); end
        3'd3: begin mul_a = 32'(e1[0]); mul_b = 32'(e2[2]); end
        3'd4: begin mul_a = 32'(e1[0]); mul_b = 32'(e2[1]); end
        3'd5: begin mul_a = 32'(e1[1]); mul_b = 32'(e2[0]); end
        default: begin mul_a = 32'(e1[1]); mul_b = 32'(e2[2]); end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_TRI && tri_ok) state_next = S_RD_A;
          else if (action == ACT_FINISH && count != '0) state_next = S_FIN_RD;
        end
      end
      S_RD_A:     state_next = S_RD_B;
      S_RD_B:     state_next = S_RD_C;
      S_RD_C:     state_next = S_GOT_C;
      S_GOT_C:    state_next = S_CROSS;
      S_CROSS:    if (cnt == 3'd6) state_next = S_ABS;
      S_ABS:      state_next = S_SHIFT;
      S_SHIFT:    if (!over) state_next = S_SQ;
      S_SQ:       if (cnt == 3'd3) state_next = S_SQRT;
      S_SQRT:     if (sbit[0]) state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV: begin
        if (k == 4'd0) begin
          if (di != 2'd2) state_next = S_DIV_INIT;
          else if (emit_mode) state_next = S_EMIT;
          else state_next = S_ACC_RD;
        end
      end
      S_ACC_RD:   state_next = S_ACC_WR;
      S_ACC_WR:   state_next = (ci == 2'd2) ? S_IDLE : S_ACC_RD;
      S_FIN_RD:   state_next = S_FIN_GOT;
      S_FIN_GOT:  state_next = S_ABS;
      S_EMIT:     if (!out_stall) state_next = is_last ? S_IDLE : S_FIN_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    vdata <= vmem[vrd_addr];
    sdata <= smem[srd_addr];
    if (state == S_IDLE && in_valid && action == ACT_LOAD && count < CNT_W'(VERT_CAP))
      vmem[count[IDX_W-1:0]] <= {pos_x, pos_y, pos_z};
    if (state == S_ACC_WR)
      smem[srd_addr] <= {sat[0], sat[1], sat[2]};
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      svalid <= '0;
    end else begin
      if (state == S_IDLE && in_valid) begin
        if (action == ACT_LOAD && count < CNT_W'(VERT_CAP)) count <= count + 1'b1;
        if (action == ACT_FINISH && count == '0) svalid <= '0;
      end
      if (state == S_ACC_WR) svalid[srd_addr] <= 1'b1;
      if (state == S_EMIT && !out_stall && is_last) begin
        svalid <= '0;
        count <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        corner[0] <= corner_a;
        corner[1] <= corner_b;
        corner[2] <= corner_c;
        ci <= 2'd0;
        fidx <= '0;
        emit_mode <= (action == ACT_FINISH);
      end
      S_RD_B: va <= vdata;
      S_RD_C: vb <= vdata;
      S_GOT_C: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= 17'(signed'(vb[47-16*i -: 16])) - 17'(signed'(va[47-16*i -: 16]));
          e2[i] <= 17'(signed'(vdata[47-16*i -: 16])) - 17'(signed'(va[47-16*i -: 16]));
        end
        cnt <= 3'd0;
      end
      S_CROSS: begin
        cnt <= cnt + 3'd1;
        if (cnt != 3'd0) begin
          if (cnt[0]) first <= signed'(prod[34:0]);
          else cv[cnt[2:1] - 2'd1] <= first - signed'(prod[34:0]);
        end
      end
      S_FIN_GOT: begin
        for (int i = 0; i < 3; i++) cv[i] <= 35'(signed'(cur[71-24*i -: 24]));
      end
      S_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= cv[i][34];
          mag[i] <= cv[i][34] ? unsigned'(-cv[i]) : unsigned'(cv[i]);
        end
      end
      S_SHIFT: begin
        if (over) for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        cnt <= 3'd0;
        sumsq <= '0;
      end
      S_SQ: begin
        cnt <= cnt + 3'd1;
        if (cnt != 3'd0) sumsq <= sumsq + unsigned'(prod[61:0]);
        sres <= '0;
        sbit <= 63'd1 << 62;
      end
      S_SQRT: begin
        if ({2'b0, sumsq} >= sq_try) begin
          sumsq <= sumsq - sq_try[61:0];
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
        di <= 2'd0;
      end
      S_DIV_INIT: begin
        rem <= {2'b0, mag[di][29:0], 14'b0} + 46'(sres[31:1]);
        q <= '0;
        k <= 4'd14;
      end
      S_DIV: begin
        if (ge) rem <= rem - den;
        q <= qf;
        k <= k - 4'd1;
        if (k == 4'd0) begin
          if (sres[31:0] == 32'd0) nrm[di] <= '0;
          else nrm[di] <= neg[di] ? -signed'({1'b0, qf}) : signed'({1'b0, qf});
          di <= di + 2'd1;
        end
      end
      S_ACC_WR: ci <= ci + 2'd1;
      S_EMIT: if (!out_stall) fidx <= fidx + 1'b1;
      default: ;
    endcase
  end

endmodule

### hdl/vna_checker.sv
// Port-level checks for vertex_normal_accumulator, bound to the top level.
// Depends on the top-level port list only.
module vna_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [5:0]         vertex_number,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic               last
);

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vertex_number) && $stable(normal_x))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during finish run");

  a_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> in_stall)
    else $error("finish run ended before last");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                  normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
                  normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
    else $error("normal out of unit range");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .vertex_number(vertex_number), .normal_x(normal_x),
  .normal_y(normal_y), .normal_z(normal_z), .last(last)
);

### tb/tb_top.sv
// Self-checking bench for vertex_normal_accumulator: queue-fed driver, clocked monitor,
// and an in-bench normal predictor that checks every emitted vertex normal in order.
// Depends on vna_pkg and the vertex_normal_accumulator RTL.
module tb_top;
  import vna_pkg::*;

  typedef struct {
    action_t           act;
    logic signed [15:0] x, y, z;
    logic [5:0]        a, b, c;
  } mesh_cmd_t;

  typedef struct {
    logic [5:0] vnum;
    int         nx, ny, nz;
    logic       fin;
  } vnormal_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, out_stall = 1'b0;
  logic [1:0] action = '0;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [5:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic in_stall, out_valid, last;
  logic [5:0] vertex_number;
  logic signed [15:0] normal_x, normal_y, normal_z;

  mesh_cmd_t cmd_queue[$];
  vnormal_t  normals_due[$];
  mesh_cmd_t next_cmd;

  // predictor state
  int mesh_x[64], mesh_y[64], mesh_z[64];
  int acc_x[64], acc_y[64], acc_z[64];
  int mesh_count = 0;

  int n_cmds = 0, n_taken = 0, n_tris = 0, n_fin = 0, n_checked = 0, errors = 0;
  int idle_in = 36, idle_out = 54;
  bit sent = 1'b0;
  int cycles = 0;

  vertex_normal_accumulator u_top (.*);

  always #6 clk = ~clk;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Q1.14 unit vector, rounding half away from zero; zero length gives zero
  task automatic unit_vec(input longint cx, cy, cz, output int nx, ny, nz);
    longint c[3];
    longint unsigned mag[3], mx, sum, len, q;
    bit neg[3];
    int n[3];
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? -c[i] : c[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      mx >>= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = (len != 0) ? (mag[i] * 16384 + len / 2) / len : 0;
      n[i] = neg[i] ? -int'(q) : int'(q);
    end
    nx = n[0]; ny = n[1]; nz = n[2];
  endtask

  function automatic int sat_sum(int s, int d);
    int r;
    r = s + d;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  task automatic predict(input logic [1:0] act, input int px, py, pz, input int a, b, c);
    longint e1[3], e2[3];
    int nx, ny, nz;
    vnormal_t exp_n;
    case (act)
      ACT_LOAD: if (mesh_count < VERT_CAP) begin
        mesh_x[mesh_count] = px; mesh_y[mesh_count] = py; mesh_z[mesh_count] = pz;
        mesh_count++;
      end
      ACT_TRI: if (a < mesh_count && b < mesh_count && c < mesh_count) begin
        n_tris++;
        e1[0] = mesh_x[b] - mesh_x[a]; e1[1] = mesh_y[b] - mesh_y[a];
        e1[2] = mesh_z[b] - mesh_z[a];
        e2[0] = mesh_x[c] - mesh_x[a]; e2[1] = mesh_y[c] - mesh_y[a];
        e2[2] = mesh_z[c] - mesh_z[a];
        unit_vec(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                 e1[0] * e2[1] - e1[1] * e2[0], nx, ny, nz);
        foreach (e1[k]) begin
          int v;
          v = (k == 0) ? a : (k == 1) ? b : c;
          acc_x[v] = sat_sum(acc_x[v], nx);
          acc_y[v] = sat_sum(acc_y[v], ny);
          acc_z[v] = sat_sum(acc_z[v], nz);
        end
      end
      ACT_FINISH: begin
        n_fin++;
        for (int i = 0; i < mesh_count; i++) begin
          unit_vec(acc_x[i], acc_y[i], acc_z[i], nx, ny, nz);
          exp_n.vnum = 6'(i); exp_n.nx = nx; exp_n.ny = ny; exp_n.nz = nz;
          exp_n.fin = (i + 1 == mesh_count);
          normals_due.insert(normals_due.size(), exp_n);
        end
        for (int i = 0; i < 64; i++) begin
          acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
        end
        mesh_count = 0;
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(input action_t act, input int x, y, z, input int a, b, c);
    mesh_cmd_t m;
    m.act = act; m.x = 16'(x); m.y = 16'(y); m.z = 16'(z);
    m.a = 6'(a); m.b = 6'(b); m.c = 6'(c);
    cmd_queue.insert(cmd_queue.size(), m);
  endtask

  function automatic int rand_coord(bit wide);
    if (wide) return int'($signed(16'($urandom)));
    return $urandom_range(0, 4095) - 2048;
  endfunction

  // nv random vertices then ntri triangles, some with unloaded corners or after an unused action, then finish
  task automatic build_mesh(input int nv, input int ntri, input bit wide);
    int a, b, c;
    for (int i = 0; i < nv; i++)
      push_cmd(ACT_LOAD, rand_coord(wide), rand_coord(wide), rand_coord(wide), 0, 0, 0);
    for (int i = 0; i < ntri; i++) begin
      a = $urandom_range(0, nv - 1);
      b = $urandom_range(0, nv - 1);
      c = $urandom_range(0, nv - 1);
      case ($urandom_range(0, 19))
        0: c = $urandom_range(nv < 64 ? nv : 0, 63);
        1: push_cmd(ACT_NONE, $urandom, $urandom, $urandom, a, b, c);
        default: ;
      endcase
      push_cmd(ACT_TRI, $urandom, $urandom, $urandom, a, b, c);
    end
    push_cmd(ACT_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // driver: next transfer offered, or valid dropped at random, at the falling edge after the previous one
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || sent) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_in) begin
          next_cmd = cmd_queue.pop_front();
          action <= next_cmd.act;
          pos_x <= next_cmd.x; pos_y <= next_cmd.y; pos_z <= next_cmd.z;
          corner_a <= next_cmd.a; corner_b <= next_cmd.b; corner_c <= next_cmd.c;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_out);
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    cycles++;
    sent = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      sent = 1'b1;
      n_taken++;
      predict(action, int'(pos_x), int'(pos_y), int'(pos_z),
              int'(corner_a), int'(corner_b), int'(corner_c));
      if (n_taken >= 2 * n_cmds / 3) begin
        idle_in = 0; idle_out = 0;
      end else if (n_taken >= n_cmds / 3) begin
        idle_in = 54; idle_out = 36;
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected normal for vertex %0d", $time, vertex_number);
        errors++;
      end else begin
        vnormal_t e;
        e = normals_due.pop_front();
        n_checked++;
        if (vertex_number !== e.vnum || normal_x !== e.nx[15:0] || normal_y !== e.ny[15:0]
            || normal_z !== e.nz[15:0] || last !== e.fin) begin
          $display("%0t: mismatch expected v%0d (%0d,%0d,%0d) last=%0d", $time,
                   e.vnum, e.nx, e.ny, e.nz, e.fin);
          $display("%0t:          actual v%0d (%0d,%0d,%0d) last=%0d", $time,
                   vertex_number, normal_x, normal_y, normal_z, last);
          errors++;
        end
      end
    end
    if (cycles > 3000000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // directed: empty finish, extremes, degenerate and unloaded corners, unused action
    push_cmd(ACT_FINISH, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_LOAD, 32767, -32768, 0, 0, 0, 0);
    push_cmd(ACT_LOAD, -32768, 32767, 32767, 0, 0, 0);
    push_cmd(ACT_LOAD, 0, -32768, -32768, 0, 0, 0);
    push_cmd(ACT_LOAD, 256, 256, 256, 0, 0, 0);
    push_cmd(ACT_LOAD, 512, 512, 512, 0, 0, 0);
    push_cmd(ACT_TRI, 0, 0, 0, 0, 1, 2);
    push_cmd(ACT_TRI, 0, 0, 0, 2, 1, 0);
    push_cmd(ACT_TRI, 0, 0, 0, 3, 4, 4);
    push_cmd(ACT_TRI, 0, 0, 0, 0, 3, 4);
    push_cmd(ACT_TRI, 0, 0, 0, 0, 1, 63);
    push_cmd(ACT_TRI, 0, 0, 0, 5, 1, 2);
    push_cmd(ACT_NONE, -1, -1, -1, 63, 63, 63);
    push_cmd(ACT_FINISH, 0, 0, 0, 0, 0, 0);
    // repeated triangles, both normal signs, accumulating on the same corners
    push_cmd(ACT_LOAD, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_LOAD, 256, 0, 0, 0, 0, 0);
    push_cmd(ACT_LOAD, 0, 256, 0, 0, 0, 0);
    push_cmd(ACT_LOAD, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_LOAD, 0, 256, 0, 0, 0, 0);
    push_cmd(ACT_LOAD, 256, 0, 0, 0, 0, 0);
    for (int i = 0; i < 20; i++) begin
      push_cmd(ACT_TRI, 0, 0, 0, 0, 1, 2);
      push_cmd(ACT_TRI, 0, 0, 0, 3, 4, 5);
    end
    push_cmd(ACT_FINISH, 0, 0, 0, 0, 0, 0);
    // full store, an overflow load, triangles on the top indices
    build_mesh(64, 20, 1'b1);
    void'(cmd_queue.pop_back());
    push_cmd(ACT_LOAD, 1, 2, 3, 0, 0, 0);
    push_cmd(ACT_TRI, 0, 0, 0, 63, 62, 61);
    push_cmd(ACT_TRI, 0, 0, 0, 63, 0, 31);
    push_cmd(ACT_FINISH, 0, 0, 0, 0, 0, 0);
    // random meshes
    repeat (5) build_mesh($urandom_range(3, 10), $urandom_range(3, 12),
                          1'($urandom_range(0, 1)));
    n_cmds = cmd_queue.size();

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    wait (cmd_queue.size() == 0 && !in_valid && normals_due.size() == 0);
    repeat (300) @(posedge clk);
    $display("Ran %0d commands: %0d live triangles, %0d finishes, %0d normals checked",
             n_taken, n_tris, n_fin, n_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### sim.f
hdl/vna_pkg.sv
hdl/vertex_normal_accumulator.sv
hdl/vna_checker.sv
tb/tb_top.sv
